/* sv/sct_pkg.sv */
// Shared types and constants of the sprite corner transform.
`default_nettype none

package sct_pkg;

  localparam int unsigned FX_W        = 32;
  localparam int unsigned SIZE_W      = 26;
  localparam int unsigned ZOOM_W      = 24;
  localparam int unsigned ANGLE_W     = 25;
  localparam int unsigned FLIP_W      = 2;
  localparam int unsigned TILE_W      = 12;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned TRIG_W      = 18;
  localparam int unsigned IN_TDATA_W  = 184;
  localparam int unsigned OUT_TDATA_W = 144;

  // 1.0 in 16.16, full turn of 360 degrees in 16.16
  localparam logic [ZOOM_W-1:0]  ZOOM_ONE  = 24'd65536;
  localparam logic [ANGLE_W-1:0] FULL_TURN = 25'd23592960;
  localparam logic [ANGLE_W-1:0] DEG_TURN  = 25'd360;
  // floor(2^34 / 360), quotient estimate is low by at most one
  localparam int unsigned        RECIP_SH  = 34;
  localparam logic [25:0]        RECIP_360 = 26'd47721858;

  typedef enum logic [KIND_W-1:0] {
    KIND_NORMAL    = 2'd0,
    KIND_SCALED    = 2'd1,
    KIND_DISTORTED = 2'd2
  } draw_kind_e;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  typedef struct packed {
    fx_t                       pos_x;
    fx_t                       pos_y;
    logic [SIZE_W-1:0]         width_fx;
    logic [SIZE_W-1:0]         height_fx;
    logic [ZOOM_W-1:0]         zoom;
    logic signed [ANGLE_W-1:0] rotation;
    logic [FLIP_W-1:0]         flip_bits;
    logic [TILE_W-1:0]         tile_index;
  } sprite_t;

  typedef struct packed {
    draw_kind_e        kind;
    fx_t               pos_x;
    fx_t               pos_y;
    fx_t               cen_x;
    fx_t               cen_y;
    fx_t               half_x;
    fx_t               half_y;
    fx_t               neg_x;
    fx_t               neg_y;
    logic [FLIP_W-1:0] flip;
    logic [TILE_W-1:0] tile;
  } geom_t;

  typedef struct packed {
    draw_kind_e                kind;
    logic signed [COORD_W-1:0] corner0_x;
    logic signed [COORD_W-1:0] corner0_y;
    logic signed [COORD_W-1:0] corner1_x;
    logic signed [COORD_W-1:0] corner1_y;
    logic signed [COORD_W-1:0] corner2_x;
    logic signed [COORD_W-1:0] corner2_y;
    logic signed [COORD_W-1:0] corner3_x;
    logic signed [COORD_W-1:0] corner3_y;
    logic [FLIP_W-1:0]         flip_out;
    logic [TILE_W-1:0]         tile_out;
  } corners_t;

endpackage

`default_nettype wire

/* sv/sct_front.sv */
// Front pipeline: draw kind decode, zoomed size, centre and sine table index.
`default_nettype none

module sct_front
  import sct_pkg::*;
#(
  parameter  int unsigned SINE_STEPS = 1024,
  localparam int unsigned IDX_W      = $clog2(SINE_STEPS)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  sprite_t          sprite_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output geom_t            geom_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam int unsigned STEP_W = $clog2(SINE_STEPS + 1);
  localparam int unsigned TP_W   = ANGLE_W + STEP_W;
  localparam int unsigned QP_W   = ANGLE_W + 26;

  // stage 1
  logic                   v1_q;
  draw_kind_e             kind1_q, kind1_d;
  fx_t                    px1_q, py1_q, hx1_q, hy1_q;
  logic [ANGLE_W-1:0]     n1_q, n1_d;
  logic [FLIP_W-1:0]      flip1_q;
  logic [TILE_W-1:0]      tile1_q;
  logic [SIZE_W-1:0]      op_w, op_h;
  logic [SIZE_W+ZOOM_W-1:0] prod_w, prod_h;
  logic [ANGLE_W-1:0]     ang;
  logic [TP_W-1:0]        turn_prod;

  // stage 2
  logic                   v2_q;
  geom_t                  geom2_q, geom2_d;
  logic [ANGLE_W-1:0]     n2_q;
  logic [IDX_W-1:0]       q2_q, q2_d;
  logic [QP_W-1:0]        quot_prod;

  // stage 3
  logic                   v3_q;
  geom_t                  geom3_q;
  logic [IDX_W-1:0]       idx3_q, idx3_d;
  logic [ANGLE_W-1:0]     rem3;

  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    if (sprite_i.rotation == '0) begin
      kind1_d = (sprite_i.zoom == ZOOM_ONE) ? KIND_NORMAL : KIND_SCALED;
    end else begin
      kind1_d = KIND_DISTORTED;
    end
    // distorted sprites rotate the half size about the centre
    op_w   = (kind1_d == KIND_DISTORTED) ? (sprite_i.width_fx >> 1) : sprite_i.width_fx;
    op_h   = (kind1_d == KIND_DISTORTED) ? (sprite_i.height_fx >> 1) : sprite_i.height_fx;
    prod_w = (SIZE_W+ZOOM_W)'(op_w) * (SIZE_W+ZOOM_W)'(sprite_i.zoom);
    prod_h = (SIZE_W+ZOOM_W)'(op_h) * (SIZE_W+ZOOM_W)'(sprite_i.zoom);
    // one full turn added brings any negative angle into [0, 360)
    ang       = sprite_i.rotation[ANGLE_W-1] ?
                ANGLE_W'(sprite_i.rotation) + FULL_TURN : ANGLE_W'(sprite_i.rotation);
    turn_prod = TP_W'(ang) * TP_W'(SINE_STEPS);
    n1_d      = ANGLE_W'(turn_prod >> 16);
  end

  always_comb begin
    quot_prod       = QP_W'(n1_q) * QP_W'(RECIP_360);
    q2_d            = IDX_W'(quot_prod >> RECIP_SH);
    geom2_d.kind    = kind1_q;
    geom2_d.pos_x   = px1_q;
    geom2_d.pos_y   = py1_q;
    geom2_d.cen_x   = px1_q + hx1_q;
    geom2_d.cen_y   = py1_q + hy1_q;
    geom2_d.half_x  = hx1_q;
    geom2_d.half_y  = hy1_q;
    geom2_d.neg_x   = -hx1_q;
    geom2_d.neg_y   = -hy1_q;
    geom2_d.flip    = flip1_q;
    geom2_d.tile    = tile1_q;
  end

  always_comb begin
    rem3   = n2_q - ANGLE_W'(q2_q) * DEG_TURN;
    idx3_d = (rem3 >= DEG_TURN) ? q2_q + IDX_W'(1) : q2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      kind1_q <= kind1_d;
      px1_q   <= sprite_i.pos_x;
      py1_q   <= sprite_i.pos_y;
      hx1_q   <= prod_w[FX_W+15:16];
      hy1_q   <= prod_h[FX_W+15:16];
      n1_q    <= n1_d;
      flip1_q <= sprite_i.flip_bits;
      tile1_q <= sprite_i.tile_index;
    end
    if (rdy2 && v1_q) begin
      geom2_q <= geom2_d;
      n2_q    <= n1_q;
      q2_q    <= q2_d;
    end
    if (rdy3 && v2_q) begin
      geom3_q <= geom2_q;
      idx3_q  <= idx3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign geom_o      = geom3_q;
  assign idx_o       = idx3_q;

endmodule

`default_nettype wire

/* sv/sct_trig_rom.sv */
// Sine and cosine lookup, one entry per angle step, registered read.
`default_nettype none

module sct_trig_rom
  import sct_pkg::*;
#(
  parameter  int unsigned SINE_STEPS = 1024,
  localparam int unsigned IDX_W      = $clog2(SINE_STEPS)
) (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire  [IDX_W-1:0] addr_i,
  output trig_t            sin_o,
  output trig_t            cos_o
);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  // sine, or cosine when cosine is set, of the step's phase: Taylor series in Q30 on
  // the first quadrant, rounded half up to signed 2.16
  function automatic trig_t trig_entry(input logic [63:0] step, input logic cosine);
    logic [63:0] ph;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] mag;
    logic [1:0]  quad;
    ph = ((step << 32) / SINE_STEPS) & 64'hFFFF_FFFF;
    if (cosine) ph = (ph + 64'h4000_0000) & 64'hFFFF_FFFF;
    quad = ph[31:30];
    r    = ph & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'h4000_0000 - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    // nested Horner form, highest order term first
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    mag = (((x * t) >> 30) + 64'd8192) >> 14;
    return quad[1] ? -TRIG_W'(mag) : TRIG_W'(mag);
  endfunction

  trig_t sin_tab [SINE_STEPS];
  trig_t cos_tab [SINE_STEPS];
  trig_t sin_q, cos_q;

  for (genvar i = 0; i < SINE_STEPS; i++) begin : g_entry
    localparam trig_t SinV = trig_entry(64'(i), 1'b0);
    localparam trig_t CosV = trig_entry(64'(i), 1'b1);
    assign sin_tab[i] = SinV;
    assign cos_tab[i] = CosV;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_tab[addr_i];
      cos_q <= cos_tab[addr_i];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

/* sv/sct_rotate.sv */
// Back pipeline: rotation products, then corner sums and the output register.
`default_nettype none

module sct_rotate
  import sct_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  geom_t    geom_i,
  input  trig_t    sin_i,
  input  trig_t    cos_i,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  output corners_t corners_o
);

  // 16.16 product floored, wrapped to 32 bits
  function automatic fx_t fx_mul(input fx_t a, input trig_t b);
    logic signed [FX_W+TRIG_W-1:0] p;
    p = (FX_W+TRIG_W)'(a) * (FX_W+TRIG_W)'(b);
    return p[FX_W+15:16];
  endfunction

  logic     vp_q, vo_q;
  geom_t    geom_q;
  // x*cos, y*sin, x*sin, y*cos for both signs of the half size
  fx_t      a_pos_q, a_neg_q, b_pos_q, b_neg_q;
  fx_t      c_pos_q, c_neg_q, d_pos_q, d_neg_q;
  corners_t out_q, out_d;
  fx_t      x0, y0, x1, y1, x2, y2, x3, y3;
  logic     rdy_p, rdy_o;

  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy_p      = !vp_q || rdy_o;
  assign in_ready_o = rdy_p;

  always_comb begin
    x0 = a_neg_q - b_neg_q + geom_q.cen_x;
    y0 = c_neg_q + d_neg_q + geom_q.cen_y;
    x1 = a_pos_q - b_neg_q + geom_q.cen_x;
    y1 = c_pos_q + d_neg_q + geom_q.cen_y;
    x2 = a_pos_q - b_pos_q + geom_q.cen_x;
    y2 = c_pos_q + d_pos_q + geom_q.cen_y;
    x3 = a_neg_q - b_pos_q + geom_q.cen_x;
    y3 = c_neg_q + d_pos_q + geom_q.cen_y;

    out_d          = '0;
    out_d.kind     = geom_q.kind;
    out_d.flip_out = geom_q.flip;
    out_d.tile_out = geom_q.tile;
    case (geom_q.kind)
      KIND_NORMAL: begin
        out_d.corner0_x = geom_q.pos_x[31:16];
        out_d.corner0_y = geom_q.pos_y[31:16];
      end
      KIND_SCALED: begin
        out_d.corner0_x = geom_q.pos_x[31:16];
        out_d.corner0_y = geom_q.pos_y[31:16];
        out_d.corner1_x = geom_q.cen_x[31:16];
        out_d.corner1_y = geom_q.cen_y[31:16];
      end
      KIND_DISTORTED: begin
        out_d.corner0_x = x0[31:16];
        out_d.corner0_y = y0[31:16];
        out_d.corner1_x = x1[31:16];
        out_d.corner1_y = y1[31:16];
        out_d.corner2_x = x2[31:16];
        out_d.corner2_y = y2[31:16];
        out_d.corner3_x = x3[31:16];
        out_d.corner3_y = y3[31:16];
      end
      default: out_d.kind = geom_q.kind;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_p) vp_q <= in_valid_i;
      if (rdy_o) vo_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && in_valid_i) begin
      geom_q  <= geom_i;
      a_pos_q <= fx_mul(geom_i.half_x, cos_i);
      a_neg_q <= fx_mul(geom_i.neg_x,  cos_i);
      b_pos_q <= fx_mul(geom_i.half_y, sin_i);
      b_neg_q <= fx_mul(geom_i.neg_y,  sin_i);
      c_pos_q <= fx_mul(geom_i.half_x, sin_i);
      c_neg_q <= fx_mul(geom_i.neg_x,  sin_i);
      d_pos_q <= fx_mul(geom_i.half_y, cos_i);
      d_neg_q <= fx_mul(geom_i.neg_y,  cos_i);
    end
    if (rdy_o && vp_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vo_q;
  assign corners_o   = out_q;

endmodule

`default_nettype wire

/* sv/sprite_corner_transform.sv */
// Throughput: one sprite per cycle unless the master side stalls; every stage holds one
//   sprite and each multiplier and the sine/cosine lookup serve one sprite per cycle.
// Stages: size product, centre and angle quotient, quotient correction, table read,
//   rotation products, corner sums into the output register.
// Reset: rst_ni clears all valid bits at once; the block accepts words the cycle after release.
`default_nettype none

module sprite_corner_transform
  import sct_pkg::*;
#(
  parameter int unsigned SINE_STEPS = 1024
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // slave side, one sprite per word
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x[31:0], pos_y[63:32], width_fx[89:64], height_fx[115:90], zoom[139:116],
  // rotation[164:140], flip_bits[166:165], tile_index[178:167], zero[183:179]
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,
  // master side, one draw command per word
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // corner0_x[15:0], corner0_y[31:16], corner1_x[47:32], corner1_y[63:48],
  // corner2_x[79:64], corner2_y[95:80], corner3_x[111:96], corner3_y[127:112],
  // flip_out[129:128], tile_out[141:130], zero[143:142]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // draw_kind[1:0]
  output logic [KIND_W-1:0]      m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(SINE_STEPS);

  sprite_t          sprite;
  logic             front_valid, front_ready;
  geom_t            front_geom;
  logic [IDX_W-1:0] front_idx;

  // table read stage: hold the geometry beside the registered lookup
  logic             v4_q;
  geom_t            geom4_q;
  logic             rdy4;
  trig_t            sin_val, cos_val;
  logic             rot_ready;

  corners_t         corners;

  // unpack the slave word, lowest field first
  assign sprite.pos_x      = s_axis_tdata[31:0];
  assign sprite.pos_y      = s_axis_tdata[63:32];
  assign sprite.width_fx   = s_axis_tdata[89:64];
  assign sprite.height_fx  = s_axis_tdata[115:90];
  assign sprite.zoom       = s_axis_tdata[139:116];
  assign sprite.rotation   = s_axis_tdata[164:140];
  assign sprite.flip_bits  = s_axis_tdata[166:165];
  assign sprite.tile_index = s_axis_tdata[178:167];

  sct_front #(
    .SINE_STEPS (SINE_STEPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sprite_i    (sprite),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .geom_o      (front_geom),
    .idx_o       (front_idx)
  );

  // advance into the table stage whenever it is empty or drains this cycle
  assign rdy4        = !v4_q || rot_ready;
  assign front_ready = rdy4;

  sct_trig_rom #(
    .SINE_STEPS (SINE_STEPS)
  ) u_trig_rom (
    .clk_i  (clk_i),
    .en_i   (rdy4 && front_valid),
    .addr_i (front_idx),
    .sin_o  (sin_val),
    .cos_o  (cos_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= front_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && front_valid) begin
      geom4_q <= front_geom;
    end
  end

  sct_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .in_ready_o  (rot_ready),
    .geom_i      (geom4_q),
    .sin_i       (sin_val),
    .cos_i       (cos_val),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .corners_o   (corners)
  );

  // pack the master word, lowest field first
  assign m_axis_tdata = {2'b00, corners.tile_out, corners.flip_out,
                         corners.corner3_y, corners.corner3_x,
                         corners.corner2_y, corners.corner2_x,
                         corners.corner1_y, corners.corner1_x,
                         corners.corner0_y, corners.corner0_x};
  assign m_axis_tuser = corners.kind;

endmodule

`default_nettype wire

/* sv/sct_checker.sv */
// Port checker for the sprite corner transform, bound to the top level.
`default_nettype none

module sct_checker
  import sct_pkg::*;
(
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tready,
  input wire                   m_axis_tvalid,
  input wire                   m_axis_tready,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire [KIND_W-1:0]      m_axis_tuser
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a normal sprite carries only its first corner
  a_normal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_NORMAL) |-> (m_axis_tdata[127:32] == '0))
    else $error("normal sprite with non-zero unused corners");

  // a scaled sprite carries two corners
  a_scaled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SCALED) |-> (m_axis_tdata[127:64] == '0))
    else $error("scaled sprite with non-zero unused corners");

  // an empty output register must leave the slave side open
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("slave side blocked with no result waiting");

endmodule

bind sprite_corner_transform sct_checker u_sct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* tb/sv/sprite_corner_transform_test.sv */
// Self-checking stream testbench for the sprite corner transform.
module sprite_corner_transform_test;
  import sct_pkg::*;

  localparam int unsigned SINE_STEPS = 1024;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          REPORT_LIMIT = 10;
  localparam longint      DEG_FX = 65536;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;

  corners_t pending_cmds[$];
  corners_t next_cmd;
  int mismatches = 0;
  int idle_cycles = 0;
  int input_stall_cycles = 0;
  int sprites_sent = 0;
  int normal_seen = 0;
  int scaled_seen = 0;
  int distorted_seen = 0;
  bit source_steady = 1'b0;
  bit sink_steady = 1'b0;
  int sink_hold_req = 0;

  sprite_corner_transform #(.SINE_STEPS(SINE_STEPS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------

  // Keep the low 32 bits, sign-extended.
  function automatic longint wrap_fx(input longint v);
    int low;
    low = v[31:0];
    return low;
  endfunction

  // Full product, floor shift by 16, wrap to 32 bits.
  function automatic longint fx_product(input longint a, input longint b);
    longint p;
    int low;
    p = a * b;
    low = p[47:16];
    return low;
  endfunction

  // Sine of a 32-bit turn fraction in 16.16: Taylor series in Q30 on the
  // first-quadrant angle, rounded half up.
  function automatic longint turn_sine(input int unsigned phase);
    longint unsigned r, x, x2, t, v, div;
    r = phase[29:0];
    if (phase[30]) begin
      r = Q30_ONE - r;
    end
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: div = 156;
        1: div = 110;
        2: div = 72;
        3: div = 42;
        4: div = 20;
        default: div = 6;
      endcase
      t = Q30_ONE - ((x2 * t) >> 30) / div;
    end
    v = (((x * t) >> 30) + 64'd8192) >> 14;
    return phase[31] ? -longint'(v) : longint'(v);
  endfunction

  // Work out the draw command that one sprite should produce.
  function automatic corners_t predict_command(input sprite_t s);
    corners_t c;
    longint px, py, w, h, z, rot, hx, hy, ox, oy, cx, cy, turn, sn, cs, vx, vy;
    longint unsigned step_idx;
    int unsigned phase;
    logic signed [COORD_W-1:0] qx[4];
    logic signed [COORD_W-1:0] qy[4];
    c = '0;
    c.flip_out = s.flip_bits;
    c.tile_out = s.tile_index;
    px = longint'($signed(s.pos_x));
    py = longint'($signed(s.pos_y));
    w = longint'(s.width_fx);
    h = longint'(s.height_fx);
    z = longint'(s.zoom);
    rot = longint'($signed(s.rotation));
    if (z == longint'(ZOOM_ONE) && rot == 0) begin
      c.kind = KIND_NORMAL;
      c.corner0_x = px[31:16];
      c.corner0_y = py[31:16];
    end else if (rot == 0) begin
      c.kind = KIND_SCALED;
      c.corner0_x = px[31:16];
      c.corner0_y = py[31:16];
      vx = wrap_fx(fx_product(w, z) + px);
      vy = wrap_fx(fx_product(h, z) + py);
      c.corner1_x = vx[31:16];
      c.corner1_y = vy[31:16];
    end else begin
      c.kind = KIND_DISTORTED;
      hx = fx_product(w >> 1, z);
      hy = fx_product(h >> 1, z);
      ox = wrap_fx(-hx);
      oy = wrap_fx(-hy);
      cx = wrap_fx(px + hx);
      cy = wrap_fx(py + hy);
      // reduce into [0, 360) degrees, then quantise to the table step
      turn = ((rot % longint'(FULL_TURN)) + longint'(FULL_TURN)) % longint'(FULL_TURN);
      step_idx = $unsigned(turn) * SINE_STEPS / FULL_TURN;
      phase = (step_idx << 32) / SINE_STEPS;
      sn = turn_sine(phase);
      cs = turn_sine(phase + 32'h4000_0000);
      // upper left, upper right, lower right, lower left before rotation
      for (int i = 0; i < 4; i++) begin
        if (i == 1 || i == 3) begin
          ox = wrap_fx(-ox);
        end
        if (i == 2) begin
          oy = wrap_fx(-oy);
        end
        vx = wrap_fx(fx_product(ox, cs) - fx_product(oy, sn) + cx);
        vy = wrap_fx(fx_product(ox, sn) + fx_product(oy, cs) + cy);
        qx[i] = vx[31:16];
        qy[i] = vy[31:16];
      end
      c.corner0_x = qx[0];
      c.corner0_y = qy[0];
      c.corner1_x = qx[1];
      c.corner1_y = qy[1];
      c.corner2_x = qx[2];
      c.corner2_y = qy[2];
      c.corner3_x = qx[3];
      c.corner3_y = qy[3];
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sprite_t make_sprite(input longint px, input longint py,
                                          input longint w, input longint h,
                                          input longint z, input longint rot,
                                          input int flip, input int tile);
    sprite_t s;
    s.pos_x = px[31:0];
    s.pos_y = py[31:0];
    s.width_fx = w[SIZE_W-1:0];
    s.height_fx = h[SIZE_W-1:0];
    s.zoom = z[ZOOM_W-1:0];
    s.rotation = rot[ANGLE_W-1:0];
    s.flip_bits = flip[FLIP_W-1:0];
    s.tile_index = tile[TILE_W-1:0];
    return s;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one; never a gap when steady.
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 50);
  endfunction

  // Random sprite: the kinds mixed, positions mostly near the screen,
  // zoom mostly around unit, angles often near the quadrant edges.
  function automatic sprite_t random_sprite();
    sprite_t s;
    longint px, py, w, h, z, rot, full_range;
    int pick;
    full_range = longint'(FULL_TURN) / 2;
    if ($urandom_range(0, 9) < 7) begin
      px = longint'($urandom_range(0, 32'h0800_0000)) - 64'sh0400_0000;
      py = longint'($urandom_range(0, 32'h0800_0000)) - 64'sh0400_0000;
    end else begin
      px = longint'($urandom());
      py = longint'($urandom());
    end
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(0, 64 * 65536);
      h = $urandom_range(0, 64 * 65536);
    end else begin
      w = $urandom_range(0, 33554432);
      h = $urandom_range(0, 33554432);
    end
    if ($urandom_range(0, 9) < 6) begin
      z = $urandom_range(8192, 262144);
    end else begin
      z = $urandom_range(0, 24'hFF_FFFF);
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      z = longint'(ZOOM_ONE);
      rot = 0;
    end else if (pick < 45) begin
      rot = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        rot = longint'($urandom_range(0, 2 * 11796480)) - full_range;
      end else if (pick < 75) begin
        // below one table step: still a rotated sprite
        rot = longint'($urandom_range(0, 1000)) - 500;
      end else begin
        rot = (longint'($urandom_range(0, 4)) - 2) * 90 * DEG_FX
              + longint'($urandom_range(0, 6)) - 3;
      end
      if (rot > full_range) begin
        rot = full_range;
      end
      if (rot < -full_range) begin
        rot = -full_range;
      end
      if (rot == 0) begin
        rot = 1;
      end
    end
    s = make_sprite(px, py, w, h, z, rot, $urandom_range(0, 3), $urandom_range(0, 4095));
    return s;
  endfunction

  // Offer one sprite word and hold it until the block takes it. Enter and
  // leave at a falling edge.
  task automatic send_sprite(input sprite_t s);
    int gap;
    gap = pick_gap(source_steady);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {5'b0, s.tile_index, s.flip_bits, s.rotation, s.zoom,
                    s.height_fx, s.width_fx, s.pos_y, s.pos_x};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_cmds.push_back(predict_command(s));
    sprites_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every outstanding command has come back.
  task automatic wait_for_drain();
    s_axis_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_normal_kind();
    send_sprite(make_sprite(0, 0, 16 * 65536, 16 * 65536, ZOOM_ONE, 0, 0, 0));
    send_sprite(make_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 33554432, 33554432,
                            ZOOM_ONE, 0, 3, 4095));
    send_sprite(make_sprite(-64'sh8000_0000, -64'sh8000_0000, 0, 0, ZOOM_ONE, 0, 1, 2048));
    // a fraction below zero lands on pixel -1
    send_sprite(make_sprite(-1, -65535, 65536, 65536, ZOOM_ONE, 0, 2, 1));
  endtask

  task automatic test_scaled_kind();
    send_sprite(make_sprite(100 * 65536, 50 * 65536, 32 * 65536, 32 * 65536, 0, 0, 0, 7));
    send_sprite(make_sprite(0, 0, 33554432, 33554432, 24'hFF_FFFF, 0, 3, 4095));
    send_sprite(make_sprite(10 * 65536, 10 * 65536, 64 * 65536, 8 * 65536, 65535, 0, 1, 3));
    send_sprite(make_sprite(10 * 65536, 10 * 65536, 64 * 65536, 8 * 65536, 65537, 0, 2, 4));
    send_sprite(make_sprite(-20 * 65536, 5 * 65536, 0, 33554432, 2 * 65536, 0, 0, 100));
    // bottom-right corner wraps past the top of the coordinate range
    send_sprite(make_sprite(32'h7FFF_0000, 32'h7FFF_8000, 512 * 65536, 512 * 65536,
                            98304, 0, 3, 2));
  endtask

  task automatic test_distorted_kind();
    longint px, py, w, h;
    px = 160 * 65536;
    py = 112 * 65536;
    w = 32 * 65536;
    h = 16 * 65536;
    // non-zero angles just inside and just outside the edges of table index zero
    send_sprite(make_sprite(px, py, w, h, ZOOM_ONE, 1, 0, 0));
    send_sprite(make_sprite(px, py, w, h, ZOOM_ONE, -1, 1, 1));
    send_sprite(make_sprite(px, py, w, h, ZOOM_ONE, 23039, 2, 2));
    send_sprite(make_sprite(px, py, w, h, ZOOM_ONE, 23040, 3, 3));
    send_sprite(make_sprite(px, py, w, h, 2 * 65536, 45 * DEG_FX, 0, 4));
    send_sprite(make_sprite(px, py, w, h, ZOOM_ONE, 90 * DEG_FX, 1, 5));
    send_sprite(make_sprite(px, py, w, h, ZOOM_ONE, -90 * DEG_FX, 2, 6));
    send_sprite(make_sprite(px, py, w, h, 32768, 180 * DEG_FX, 3, 7));
    send_sprite(make_sprite(px, py, w, h, 32768, -180 * DEG_FX, 0, 4095));
    send_sprite(make_sprite(px, py, w, h, 0, 30 * DEG_FX, 1, 8));
    // oversized sprite at maximum zoom: the half-size product wraps
    send_sprite(make_sprite(0, 0, 33554432, 33554432, 24'hFF_FFFF, 60 * DEG_FX, 2, 9));
    send_sprite(make_sprite(32'h7FFF_FFFF, -64'sh8000_0000, 65537, 65537, 3 * 65536,
                            10 * DEG_FX, 3, 10));
  endtask

  // Random sprites in chunks; some chunks run with no gaps on one or both sides.
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        source_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      send_sprite(random_sprite());
    end
    source_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // pipeline fills and the slave side stalls.
  task automatic test_input_backpressure(input int count);
    source_steady = 1'b1;
    sink_hold_req = 300;
    // drop valid while the receiver picks up the hold
    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    for (int i = 0; i < count; i++) begin
      send_sprite(random_sprite());
    end
    source_steady = 1'b0;
  endtask

  // Sender pauses until the pipeline has drained completely, then resumes.
  task automatic test_drain_pause(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_for_drain();
      end
      send_sprite(random_sprite());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, stretches of steady ready, and long hold-offs
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int hold;
    int r;
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req != 0) begin
        hold = sink_hold_req;
        sink_hold_req = 0;
        m_axis_tready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      if (sink_steady) begin
        stall_left = 0;
        m_axis_tready = 1'b1;
      end else begin
        if (stall_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            stall_left = $urandom_range(1, 3);
          end else if (r < 10) begin
            stall_left = $urandom_range(10, 40);
          end
        end
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready = 1'b0;
        end else begin
          m_axis_tready = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each command word with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string tag, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("Mismatch on %s: expected %0d, got %0d (command %0d)", tag, want, got,
                 normal_seen + scaled_seen + distorted_seen);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected command word with no sprite outstanding: %h / kind %0d",
                   m_axis_tdata, m_axis_tuser);
        end
      end else begin
        next_cmd = pending_cmds.pop_front();
        check_field("draw_kind", next_cmd.kind, m_axis_tuser);
        check_field("corner0_x", next_cmd.corner0_x, $signed(m_axis_tdata[15:0]));
        check_field("corner0_y", next_cmd.corner0_y, $signed(m_axis_tdata[31:16]));
        check_field("corner1_x", next_cmd.corner1_x, $signed(m_axis_tdata[47:32]));
        check_field("corner1_y", next_cmd.corner1_y, $signed(m_axis_tdata[63:48]));
        check_field("corner2_x", next_cmd.corner2_x, $signed(m_axis_tdata[79:64]));
        check_field("corner2_y", next_cmd.corner2_y, $signed(m_axis_tdata[95:80]));
        check_field("corner3_x", next_cmd.corner3_x, $signed(m_axis_tdata[111:96]));
        check_field("corner3_y", next_cmd.corner3_y, $signed(m_axis_tdata[127:112]));
        check_field("flip_out", next_cmd.flip_out, m_axis_tdata[129:128]);
        check_field("tile_out", next_cmd.tile_out, m_axis_tdata[141:130]);
        check_field("pad", 0, m_axis_tdata[143:142]);
        case (next_cmd.kind)
          KIND_NORMAL: normal_seen++;
          KIND_SCALED: scaled_seen++;
          default: distorted_seen++;
        endcase
      end
    end
  end

  // Count slave-side stall cycles for the summary.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && !s_axis_tready) begin
      input_stall_cycles++;
    end
  end

  // Watchdog: give up if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no word moved for %0d cycles, %0d commands outstanding",
                   idle_cycles, pending_cmds.size());
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_normal_kind();
    test_scaled_kind();
    test_distorted_kind();
    test_random_mix(600);
    test_input_backpressure(150);
    test_drain_pause(80);

    // drain, then allow the pipeline depth for any stray word
    s_axis_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d sprites; checked %0d normal, %0d scaled and %0d distorted commands.",
             sprites_sent, normal_seen, scaled_seen, distorted_seen);
    $display("Slave side stalled for %0d cycles; %0d field mismatches.",
             input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sct_pkg.sv
sv/sct_front.sv
sv/sct_trig_rom.sv
sv/sct_rotate.sv
sv/sprite_corner_transform.sv
sv/sct_checker.sv
tb/sv/sprite_corner_transform_test.sv
